>>> src/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Payload structs, controller state, command/status bundles, reciprocals.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int CFG_W        = 11;
    localparam int ROW_W        = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int RECIP_SHIFT  = 18;
    localparam int RECIP_W      = 18;
    localparam int SUM_W        = 12;
    localparam int NUM_W        = 13;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic       func;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd;
        logic sum;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic has_out;
        logic out_full;
    } t_sts;

    // ceil(2^18 / (2n)) for the neighbor count n
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = 18'd131072;
        endcase
        return m;
    endfunction

endpackage

>>> src/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: 3x3 box blur of an RGB raster stream
// Mean of the in-frame 3x3 neighborhood per channel, rounded half up.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, payload i_data): pixels in raster order,
//   func = 0 for a pixel, func = 1 for a flush tick. After the last pixel of
//   a frame send frame_width + 1 flush ticks to drain the outputs; a pixel
//   sent past the frame acts as a flush tick. Flush ticks inside the frame
//   are dropped.
//   Output channel (o_valid/i_ready, payload o_data): one transfer per
//   output pixel, lagging its input by one row plus one pixel; frame_end
//   marks the bottom-right pixel, after which a new frame starts.
//   Configuration: write frame_width (index 0) or frame_height (index 1)
//   through i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle.
// Timing:
//   A pixel or drain item steps through accept, row store read, window sum
//   and reciprocal multiply into the output register (the last is skipped
//   when no output is due). The single-port row store is written in the sum phase.
//   A result is visible the cycle after the multiply phase. If the receiver
//   stalls, the result holds in the output register; the next item is still
//   taken and waits in the multiply phase until the register frees.
// Reset: size registers return to 640x480, position and window clear; row
//   stores are not cleared (rows outside the frame never reach a sum).
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  bb3_pkg::t_in                    i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output bb3_pkg::t_out                   o_data,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]       i_cfg_data
);

    bb3_pkg::t_cmd cmd;
    bb3_pkg::t_sts sts;

    // sequencer: one item at a time through the datapath phases
    bb3_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // position, row stores, window, divide and output register
    bb3_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

>>> src/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl: sequencing controller
// Steps one item through read, sum and multiply phases.
// ----------------------------------------------------------------------------
module bb3_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bb3_pkg::t_sts   i_sts,
    output bb3_pkg::t_cmd   o_cmd
);

    bb3_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bb3_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            bb3_pkg::ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid && !i_sts.ignore) begin
                    n_state = bb3_pkg::ST_READ;
                end
            end
            bb3_pkg::ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = bb3_pkg::ST_SUM;
            end
            bb3_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = i_sts.has_out ? bb3_pkg::ST_MUL : bb3_pkg::ST_IDLE;
            end
            bb3_pkg::ST_MUL: begin
                // hold until the output register frees up
                if (!i_sts.out_full) begin
                    o_cmd.load = 1'b1;
                    n_state    = bb3_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bb3_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/bb3_dp.sv
// ----------------------------------------------------------------------------
// bb3_dp: box blur datapath
// Position tracking, row stores, 3x3 window, sums and reciprocal divide.
// ----------------------------------------------------------------------------
module bb3_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bb3_pkg::t_cmd                   i_cmd,
    output bb3_pkg::t_sts                   o_sts,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]       i_cfg_data,
    input  bb3_pkg::t_in                    i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output bb3_pkg::t_out                   o_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = bb3_pkg::ROW_W;
    localparam int SW = bb3_pkg::SUM_W;
    localparam int XW = bb3_pkg::NUM_W;
    localparam int MW = bb3_pkg::RECIP_W;
    localparam int PW = XW + MW;

    logic [bb3_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [CW-1:0] w;
    logic [RW-1:0] h, h_p1;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r1, r2, nr, crow;
    logic [CW-1:0] c1, c2, c3, nc, ccol;
    logic          drain, cr_ok;

    logic [AW-1:0] r_addr;
    logic [23:0]   r_pix;
    logic          r_top, r_bot, r_left, r_right, r_last, r_has_out;

    logic [23:0]   r_older [MAX_WIDTH];
    logic [23:0]   r_newer [MAX_WIDTH];
    logic [23:0]   r_older_q, r_newer_q;

    logic [23:0]   r_wc [6];
    logic [23:0]   cur [3];
    logic [SW-1:0] sum [3];
    logic [SW-1:0] r_sum [3];
    logic [3:0]    r_n;
    logic [MW-1:0] r_recip;
    logic [1:0]    rows, cols;
    logic [7:0]    q [3];

    bb3_pkg::t_out r_out;
    logic          r_out_valid;

    // configuration, clamped for use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bb3_pkg::WIDTH_RESET;
            r_cfg_h <= bb3_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bb3_pkg::REG_FRAME_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end else begin
                r_cfg_h <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w = CW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w = CW'(MAX_WIDTH);
        end else begin
            w = CW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h = RW'(1);
        end else if (32'(r_cfg_h) > 32'(bb3_pkg::HEIGHT_LIMIT)) begin
            h = RW'(bb3_pkg::HEIGHT_LIMIT);
        end else begin
            h = r_cfg_h;
        end
        h_p1 = h + RW'(1);
    end

    // item position, wrap and restart
    always_comb begin
        if (r_col >= w) begin
            c1 = '0;
            r1 = r_row + RW'(1);
        end else begin
            c1 = r_col;
            r1 = r_row;
        end
        if (r1 > h_p1 || (r1 == h_p1 && c1 != '0)) begin
            c2 = '0;
            r2 = '0;
        end else begin
            c2 = c1;
            r2 = r1;
        end
        drain = r2 >= h;
        c3    = c2 + CW'(1);
        if (c3 >= w) begin
            nc = '0;
            nr = r2 + RW'(1);
        end else begin
            nc = c3;
            nr = r2;
        end
        if (c2 != '0) begin
            cr_ok = r2 >= RW'(1) && (r2 - RW'(1)) < h;
            crow  = r2 - RW'(1);
            ccol  = c2 - CW'(1);
        end else begin
            cr_ok = r2 >= RW'(2) && (r2 - RW'(2)) < h;
            crow  = r2 - RW'(2);
            ccol  = w - CW'(1);
        end
    end

    assign o_sts.ignore   = !drain && i_data.func;
    assign o_sts.has_out  = r_has_out;
    assign o_sts.out_full = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_addr    <= c2[AW-1:0];
            r_pix     <= drain ? 24'd0 : {i_data.red_in, i_data.green_in, i_data.blue_in};
            r_has_out <= cr_ok;
            r_top     <= crow != '0;
            r_bot     <= (crow + RW'(1)) < h;
            r_left    <= ccol != '0;
            r_right   <= (ccol + CW'(1)) < w;
            r_last    <= crow == (h - RW'(1)) && ccol == (w - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.accept) begin
            r_row <= o_sts.ignore ? r2 : nr;
            r_col <= o_sts.ignore ? c2 : nc;
        end else if (i_cmd.sum && r_has_out && r_last) begin
            r_row <= '0;
            r_col <= '0;
        end
    end

    // row stores: read one phase, rotate the column the next
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_older_q <= r_older[r_addr];
            r_newer_q <= r_newer[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_older[r_addr] <= r_newer_q;
            r_newer[r_addr] <= r_pix;
        end
    end

    // masked 3x3 sums
    always_comb begin
        logic [23:0] px;
        logic [2:0]  rok, cok;
        cur[0] = r_older_q;
        cur[1] = r_newer_q;
        cur[2] = r_pix;
        rok    = {r_bot, 1'b1, r_top};
        cok    = {r_right, 1'b1, r_left};
        rows   = 2'd1 + 2'(r_top) + 2'(r_bot);
        cols   = 2'd1 + 2'(r_left) + 2'(r_right);
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
        end
        for (int t = 0; t < 3; t++) begin
            for (int s = 0; s < 3; s++) begin
                if (s == 0) begin
                    px = r_wc[t];
                end else if (s == 1) begin
                    px = r_wc[3 + t];
                end else begin
                    px = cur[t];
                end
                if (rok[t] && cok[s]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        sum[ch] = sum[ch] + SW'(px[ch*8 +: 8]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_wc[k] <= '0;
            end
        end else if (i_cmd.sum) begin
            for (int t = 0; t < 3; t++) begin
                // clear the window at frame end, else shift in the new column
                r_wc[t]     <= (r_has_out && r_last) ? 24'd0 : r_wc[3 + t];
                r_wc[3 + t] <= (r_has_out && r_last) ? 24'd0 : cur[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_sum[ch] <= sum[ch];
            end
            r_n     <= 4'(rows) * 4'(cols);
            r_recip <= bb3_pkg::recip(4'(rows) * 4'(cols));
        end
    end

    // rounded mean: floor((2s + n) / 2n) via reciprocal multiply
    always_comb begin
        logic [XW-1:0] x;
        logic [PW-1:0] prod;
        for (int ch = 0; ch < 3; ch++) begin
            x     = XW'({r_sum[ch], 1'b0}) + XW'(r_n);
            prod  = PW'(x) * PW'(r_recip);
            q[ch] = prod[bb3_pkg::RECIP_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.red_out   <= q[2];
            r_out.green_out <= q[1];
            r_out.blue_out  <= q[0];
            r_out.frame_end <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
